// ===== design/edi_pkg.sv =====
package edi_pkg;

  // field widths of the stream words
  localparam int COORD_FIELD_BITS = 16;
  localparam int SQD_BITS         = 36;
  localparam int DIST_BITS        = 18;

  // build-time sizing
  localparam int MAX_DIMENSIONS = 16;
  localparam int COORD_BITS     = 16;

  localparam int CNT_BITS  = $clog2(MAX_DIMENSIONS + 1);
  localparam int MAG_BITS  = COORD_BITS;
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int SUM_BITS  = 37;
  localparam int ADD_BITS  = ((SUM_BITS > SQ_BITS) ? SUM_BITS : SQ_BITS) + 1;

  // highest even bit position of the root search
  localparam int ROOT_TOP  = ((SUM_BITS - 1) / 2) * 2;

  // sum queue between accumulator and root engine
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

  typedef logic [SUM_BITS-1:0] sum_t;

  typedef struct packed {
    logic valid;
    sum_t sum;
  } push_t;

  typedef struct packed {
    logic empty;
    sum_t head;
  } pop_side_t;

  typedef enum logic [2:0] {
    ROOT_IDLE = 3'b001,
    ROOT_RUN  = 3'b010,
    ROOT_FIN  = 3'b100
  } root_state_t;

endpackage

// ===== design/edi_if.sv =====
interface edi_in_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [edi_pkg::COORD_FIELD_BITS-1:0] coord_a;
  logic signed [edi_pkg::COORD_FIELD_BITS-1:0] coord_b;
  logic                                        is_last;

  modport source (output valid, output coord_a, output coord_b, output is_last, input ready);
  modport sink   (input valid, input coord_a, input coord_b, input is_last, output ready);
endinterface

interface edi_out_if;
  logic                              valid;
  logic                              ready;
  logic [edi_pkg::SQD_BITS-1:0]      squared_distance;
  logic [edi_pkg::DIST_BITS-1:0]     distance;

  modport source (output valid, output squared_distance, output distance, input ready);
  modport sink   (input valid, input squared_distance, input distance, output ready);
endinterface

// ===== design/edi_front.sv =====
module edi_front (
  input  logic            clk,
  input  logic            rst,
  edi_in_if.sink          items,
  input  logic            fifo_full,
  output edi_pkg::push_t  push
);

  logic                            advance;
  logic                            accept;
  logic [edi_pkg::CNT_BITS-1:0]    cnt;
  logic                            keep;

  logic signed [edi_pkg::COORD_BITS-1:0] a_wide;
  logic signed [edi_pkg::COORD_BITS-1:0] b_wide;
  logic signed [edi_pkg::COORD_BITS:0]   diff;
  logic [edi_pkg::MAG_BITS-1:0]          mag;

  logic                            s1_valid;
  logic                            s1_last;
  logic                            s1_keep;
  logic [edi_pkg::MAG_BITS-1:0]    s1_mag;
  logic [edi_pkg::SQ_BITS-1:0]     prod;

  logic                            s2_valid;
  logic                            s2_last;
  logic [edi_pkg::SQ_BITS-1:0]     s2_sq;

  edi_pkg::sum_t                   sum;
  logic [edi_pkg::ADD_BITS-1:0]    total;
  edi_pkg::sum_t                   total_sat;

  // whole pipe holds only when a finished sum cannot enter the queue
  assign advance     = !(s2_valid && s2_last && fifo_full);
  assign items.ready = advance;
  assign accept      = items.valid && advance;

  assign keep = cnt < edi_pkg::CNT_BITS'(edi_pkg::MAX_DIMENSIONS);

  assign a_wide = edi_pkg::COORD_BITS'(items.coord_a);
  assign b_wide = edi_pkg::COORD_BITS'(items.coord_b);
  assign diff   = $signed({a_wide[edi_pkg::COORD_BITS-1], a_wide})
                - $signed({b_wide[edi_pkg::COORD_BITS-1], b_wide});
  assign mag    = diff[edi_pkg::COORD_BITS] ? edi_pkg::MAG_BITS'(-diff)
                                            : edi_pkg::MAG_BITS'(diff);

  assign prod = s1_mag * s1_mag;

  assign total     = edi_pkg::ADD_BITS'(sum) + edi_pkg::ADD_BITS'(s2_sq);
  assign total_sat = (total > edi_pkg::ADD_BITS'({edi_pkg::SUM_BITS{1'b1}}))
                   ? {edi_pkg::SUM_BITS{1'b1}} : edi_pkg::SUM_BITS'(total);

  assign push.valid = s2_valid && s2_last && advance;
  assign push.sum   = total_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      sum      <= '0;
    end else if (advance) begin
      if (accept) begin
        if (items.is_last) begin
          cnt <= '0;
        end else if (keep) begin
          cnt <= cnt + 1'b1;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        sum <= s2_last ? '0 : total_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mag  <= mag;
      s1_keep <= keep;
      s1_last <= items.is_last;
      s2_sq   <= s1_keep ? prod : '0;
      s2_last <= s1_last;
    end
  end

endmodule

// ===== design/edi_fifo.sv =====
module edi_fifo (
  input  logic               clk,
  input  logic               rst,
  input  edi_pkg::push_t     push,
  output logic               full,
  input  logic               pop,
  output edi_pkg::pop_side_t side
);

  edi_pkg::sum_t                   mem [edi_pkg::FIFO_DEPTH];
  logic [edi_pkg::PTR_BITS-1:0]    wr_ptr;
  logic [edi_pkg::PTR_BITS-1:0]    rd_ptr;
  logic [edi_pkg::FILL_BITS-1:0]   fill;
  logic                            do_push;
  logic                            do_pop;

  assign full       = fill == edi_pkg::FILL_BITS'(edi_pkg::FIFO_DEPTH);
  assign side.empty = fill == '0;
  assign side.head  = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && !side.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.sum;
    end
  end

endmodule

// ===== design/edi_root.sv =====
module edi_root (
  input  logic               clk,
  input  logic               rst,
  input  edi_pkg::pop_side_t side,
  output logic               pop,
  edi_out_if.source          results
);

  edi_pkg::root_state_t  state;
  edi_pkg::sum_t         saved;
  edi_pkg::sum_t         rem;
  edi_pkg::sum_t         res;
  edi_pkg::sum_t         bitpos;
  logic [edi_pkg::SUM_BITS:0] trial;
  logic                  slot_free;

  assign slot_free = !results.valid || results.ready;
  assign pop       = (state == edi_pkg::ROOT_IDLE) && !side.empty;
  assign trial     = {1'b0, res} + {1'b0, bitpos};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= edi_pkg::ROOT_IDLE;
      results.valid <= 1'b0;
    end else begin
      // a new word replaces one taken in the same cycle
      if (state == edi_pkg::ROOT_FIN && slot_free) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        edi_pkg::ROOT_IDLE: begin
          if (!side.empty) begin
            state <= edi_pkg::ROOT_RUN;
          end
        end
        edi_pkg::ROOT_RUN: begin
          if (bitpos[0]) begin
            state <= edi_pkg::ROOT_FIN;
          end
        end
        edi_pkg::ROOT_FIN: begin
          if (slot_free) begin
            state <= edi_pkg::ROOT_IDLE;
          end
        end
        default: begin
          state <= edi_pkg::ROOT_IDLE;
        end
      endcase
    end
  end

  // digit-by-digit root, two bits of the radicand per step
  always_ff @(posedge clk) begin
    case (state)
      edi_pkg::ROOT_IDLE: begin
        saved  <= side.head;
        rem    <= side.head;
        res    <= '0;
        bitpos <= edi_pkg::SUM_BITS'(1) << edi_pkg::ROOT_TOP;
      end
      edi_pkg::ROOT_RUN: begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - edi_pkg::SUM_BITS'(trial);
          res <= (res >> 1) + bitpos;
        end else begin
          res <= res >> 1;
        end
        bitpos <= bitpos >> 2;
      end
      edi_pkg::ROOT_FIN: begin
        if (slot_free) begin
          results.squared_distance <= saved[edi_pkg::SUM_BITS-1:edi_pkg::SQD_BITS] != '0
                                    ? {edi_pkg::SQD_BITS{1'b1}}
                                    : saved[edi_pkg::SQD_BITS-1:0];
          results.distance <= res[edi_pkg::SUM_BITS-1:edi_pkg::DIST_BITS] != '0
                            ? {edi_pkg::DIST_BITS{1'b1}}
                            : res[edi_pkg::DIST_BITS-1:0];
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

// ===== design/euclidean_distance_integer.sv =====
// integer euclidean distance: each input word carries one coordinate pair of
// two points; the front end takes one word per cycle unless a closed sum meets
// a full queue, squares the difference in a two-stage pipe (register after the
// subtract, register after the multiplier) and adds it into a saturating 37-bit
// sum. pairs beyond MAX_DIMENSIONS of one point are ignored. the word marked
// is_last closes the point: its finished sum goes into a four-entry queue and
// the sum clears. the back end takes sums from the queue and finds the floor
// square root with one shared add-compare unit, two radicand bits per cycle in
// 19 root steps, plus load and write-out. points with at least as many
// coordinates as the engine spends cycles per point therefore flow at one word
// per cycle; shorter points are limited by the root engine once the queue fills,
// and the input stalls. the result word holds squared_distance (saturated to 36
// bits) and distance (saturated to 18 bits); it sits in an output register, so
// the engine starts the next root while a result waits to be taken

module euclidean_distance_integer (
  input  logic        clk,
  input  logic        rst,
  edi_in_if.sink      items,
  edi_out_if.source   results
);

  // finished sums from the accumulator
  edi_pkg::push_t      push;
  logic                fifo_full;

  // queue head towards the root engine
  edi_pkg::pop_side_t  side;
  logic                pop;

  // front: subtract, square, accumulate
  edi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .fifo_full (fifo_full),
    .push      (push)
  );

  // decoupling queue of closed sums
  edi_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (fifo_full),
    .pop  (pop),
    .side (side)
  );

  // back: iterative square root and result register
  edi_root u_root (
    .clk     (clk),
    .rst     (rst),
    .side    (side),
    .pop     (pop),
    .results (results)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // run limits of the bench
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_WORDS   = 850;
  localparam int HOLD_OFF_CYCLES = 300;

  // saturation points of the running sum and of the two result fields
  localparam longint unsigned SUM_LIMIT  = (64'd1 << edi_pkg::SUM_BITS) - 1;
  localparam longint unsigned SQD_LIMIT  = (64'd1 << edi_pkg::SQD_BITS) - 1;
  localparam longint unsigned DIST_LIMIT = (64'd1 << edi_pkg::DIST_BITS) - 1;

  localparam logic [edi_pkg::COORD_FIELD_BITS-1:0] COORD_MAX = 16'h7fff;
  localparam logic [edi_pkg::COORD_FIELD_BITS-1:0] COORD_MIN = 16'h8000;

  typedef struct {
    logic [edi_pkg::SQD_BITS-1:0]  squared_distance;
    logic [edi_pkg::DIST_BITS-1:0] distance;
  } distance_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  edi_in_if  in_words ();
  edi_out_if out_words ();

  euclidean_distance_integer u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (in_words),
    .results (out_words)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // own copy of the accumulator state
  longint unsigned acc_sum   = 0;
  int              acc_count = 0;

  // distances still owed by the block, oldest first
  distance_word_t pending_distances[$];

  int errors      = 0;
  int cycle_count = 0;
  int words_sent  = 0;

  // idling switches shared by the test tasks and the two sides
  bit source_idling    = 1'b0;
  bit sink_idling      = 1'b0;
  int sink_hold_cycles = 0;

  // sign-extend the low COORD_BITS bits of a coordinate field
  function automatic longint to_coord(input logic [edi_pkg::COORD_FIELD_BITS-1:0] raw);
    longint v;
    v = longint'(raw) & ((longint'(1) << edi_pkg::COORD_BITS) - 1);
    if (v[edi_pkg::COORD_BITS-1])
      v = v - (longint'(1) << edi_pkg::COORD_BITS);
    return v;
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x)
        r = t;
    end
    return r;
  endfunction

  // fold one accepted word into the sum; a closing word owes a distance
  task automatic accumulate_pair(input logic [edi_pkg::COORD_FIELD_BITS-1:0] a,
                                 input logic [edi_pkg::COORD_FIELD_BITS-1:0] b,
                                 input logic last);
    longint          diff;
    longint unsigned mag;
    longint unsigned root;
    distance_word_t  w;
    // pairs past the dimension limit add nothing
    if (acc_count < edi_pkg::MAX_DIMENSIONS) begin
      diff = to_coord(a) - to_coord(b);
      mag  = (diff < 0) ? longint'(-diff) : diff;
      acc_sum = acc_sum + mag * mag;
      if (acc_sum > SUM_LIMIT)
        acc_sum = SUM_LIMIT;
      acc_count++;
    end
    if (last) begin
      // root from the saturated 37-bit sum, both fields clipped afterwards
      root = floor_root(acc_sum);
      w.squared_distance = (acc_sum > SQD_LIMIT) ? SQD_LIMIT[edi_pkg::SQD_BITS-1:0]
                                                 : acc_sum[edi_pkg::SQD_BITS-1:0];
      w.distance = (root > DIST_LIMIT) ? DIST_LIMIT[edi_pkg::DIST_BITS-1:0]
                                       : root[edi_pkg::DIST_BITS-1:0];
      pending_distances.push_back(w);
      acc_sum   = 0;
      acc_count = 0;
    end
  endtask

  // idle stretch: mostly short, now and then long
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // offer one word and wait for the handshake; valid stays high afterwards
  task automatic send_pair(input logic [edi_pkg::COORD_FIELD_BITS-1:0] a,
                           input logic [edi_pkg::COORD_FIELD_BITS-1:0] b,
                           input logic last);
    int gap;
    gap = 0;
    if (source_idling && $urandom_range(0, 3) == 0)
      gap = gap_length();
    if (gap > 0) begin
      in_words.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_words.valid   <= 1'b1;
    in_words.coord_a <= a;
    in_words.coord_b <= b;
    in_words.is_last <= last;
    do
      @(posedge clk);
    while (!in_words.ready);
    accumulate_pair(a, b, last);
  endtask

  // sender pauses until every owed distance has come back
  task automatic wait_for_results();
    in_words.valid <= 1'b0;
    while (pending_distances.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // coordinate mix: extremes, values near zero, and the full range
  function automatic logic [edi_pkg::COORD_FIELD_BITS-1:0] rand_coord();
    logic signed [edi_pkg::COORD_FIELD_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = COORD_MAX;
      1: v = COORD_MIN;
      2: begin
        v = edi_pkg::COORD_FIELD_BITS'($urandom_range(0, 8));
        v = v - 16'sd4;
      end
      default: v = edi_pkg::COORD_FIELD_BITS'($urandom());
    endcase
    return v;
  endfunction

  // one point pair of the given length with random coordinates
  task automatic send_random_point(input int len);
    for (int i = 0; i < len; i++) begin
      send_pair(rand_coord(), rand_coord(), i == len - 1);
      if (i < edi_pkg::MAX_DIMENSIONS)
        words_sent++;
    end
  endtask

  // single-coordinate points, including the largest difference both ways
  task automatic test_single_coordinate();
    source_idling = 1'b0;
    sink_idling   = 1'b0;
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(COORD_MAX, COORD_MIN, 1'b1);
    send_pair(COORD_MIN, COORD_MAX, 1'b1);
    wait_for_results();
  endtask

  // full-size point at the extremes, with two surplus pairs that must be ignored
  task automatic test_extreme_point();
    for (int i = 0; i < edi_pkg::MAX_DIMENSIONS + 2; i++)
      send_pair(COORD_MAX, COORD_MIN, i == edi_pkg::MAX_DIMENSIONS + 1);
    wait_for_results();
  endtask

  // small mixed-sign points
  task automatic test_mixed_signs();
    send_pair(16'hffff, 16'h0001, 1'b0);
    send_pair(16'h0005, 16'h0005, 1'b1);
    send_pair(COORD_MIN, COORD_MIN, 1'b0);
    send_pair(16'h0064, 16'hff9c, 1'b1);
    wait_for_results();
  endtask

  // random points: mostly short, some at or beyond the dimension limit
  task automatic test_random_points();
    int points;
    int r;
    int len;
    points = 0;
    while (words_sent < RANDOM_WORDS) begin
      // re-pick the idling pattern every few dozen points
      if (points % 40 == 0) begin
        r = $urandom_range(0, 3);
        source_idling = r[0];
        sink_idling   = r[1];
      end
      r = $urandom_range(0, 9);
      if (r <= 5)
        len = $urandom_range(1, 4);
      else if (r <= 7)
        len = $urandom_range(5, edi_pkg::MAX_DIMENSIONS);
      else if (r == 8)
        len = edi_pkg::MAX_DIMENSIONS;
      else
        len = $urandom_range(edi_pkg::MAX_DIMENSIONS + 1, edi_pkg::MAX_DIMENSIONS + 8);
      send_random_point(len);
      points++;
      // sender pauses now and then until everything is back
      if (points % 100 == 0)
        wait_for_results();
    end
    wait_for_results();
  endtask

  // receiver holds off for a long stretch while short points keep coming
  task automatic test_backpressure();
    source_idling    = 1'b0;
    sink_idling      = 1'b0;
    sink_hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 40; i++)
      send_random_point($urandom_range(1, 2));
    wait_for_results();
  endtask

  // receiver side: ready with random gaps, plus a long hold when asked
  initial begin : sink_side
    int n;
    out_words.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_words.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_idling && $urandom_range(0, 3) == 0) begin
        out_words.ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end else begin
        out_words.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each accepted result word with the oldest owed distance
  always @(posedge clk) begin : check_results
    distance_word_t want;
    if (!rst && out_words.valid && out_words.ready) begin
      if (pending_distances.size() == 0) begin
        $error("result word with nothing pending: squared_distance %0d, distance %0d",
               out_words.squared_distance, out_words.distance);
        errors++;
      end else begin
        want = pending_distances.pop_front();
        if (out_words.squared_distance !== want.squared_distance) begin
          $error("squared_distance: expected %0d, got %0d",
                 want.squared_distance, out_words.squared_distance);
          errors++;
        end
        if (out_words.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_words.distance);
          errors++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_words.valid   <= 1'b0;
    in_words.coord_a <= '0;
    in_words.coord_b <= '0;
    in_words.is_last <= 1'b0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_coordinate();
    test_extreme_point();
    test_mixed_signs();
    test_backpressure();
    test_random_points();
    test_backpressure();

    // everything is back and the pipe has had time to settle
    wait_for_results();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/edi_pkg.sv
design/edi_if.sv
design/edi_front.sv
design/edi_fifo.sv
design/edi_root.sv
design/euclidean_distance_integer.sv
tb/testbench.sv
